@@ hdl/rma_pkg.sv @@
// ----------------------------------------------------------------------------
// rma_pkg: shared types and constants of the record moving average
// Sample width, divider step count, controller states and the command and
// status groups exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package rma_pkg;

	localparam int MAX_WINDOW_DEF = 64;
	localparam int SAMPLE_W       = 8;
	localparam int WIN_W          = 7;
	// quotient never exceeds the sample range, so one bit per step
	localparam int DIV_STEPS      = SAMPLE_W;
	localparam int STEP_W         = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_pass;
		logic div_start;
		logic div_step;
		logic div_finish;
		logic advance;
		logic rec_end;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pend_zero;
		logic pass_mode;
		logic div_ready;
	} dp_status_t;

endpackage

@@ hdl/rma_ram.sv @@
// ----------------------------------------------------------------------------
// rma_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/rma_ctrl.sv @@
// ----------------------------------------------------------------------------
// rma_ctrl: sequencer of the record moving average
// Takes one item, then emits its pending points one at a time, through the
// shared divider or passed straight through, and the output register.
// ----------------------------------------------------------------------------
module rma_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  rma_pkg::dp_status_t stat,
	output rma_pkg::ctrl_cmd_t  cmd
);

	rma_pkg::state_t                state_q;
	rma_pkg::state_t                state_nxt;
	logic [rma_pkg::STEP_W-1:0]     step_q;
	logic                           step_last;
	logic                           emit_any;

	assign step_last = (step_q == rma_pkg::STEP_W'(rma_pkg::DIV_STEPS - 1));
	assign emit_any  = !stat.pend_zero && (stat.pass_mode || stat.div_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rma_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == rma_pkg::ST_DIV) begin
				step_q <= step_q + rma_pkg::STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rma_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = rma_pkg::ST_DECIDE;
				end
			end
			rma_pkg::ST_DECIDE: begin
				if (!emit_any) begin
					state_nxt = rma_pkg::ST_IDLE;
				end else if (stat.pass_mode) begin
					state_nxt = rma_pkg::ST_OUT;
				end else begin
					state_nxt = rma_pkg::ST_DIV;
				end
			end
			rma_pkg::ST_DIV: begin
				if (step_last) begin
					state_nxt = rma_pkg::ST_OUT;
				end
			end
			rma_pkg::ST_OUT: begin
				if (m_tready) begin
					state_nxt = rma_pkg::ST_DECIDE;
				end
			end
			default: state_nxt = rma_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = (state_q == rma_pkg::ST_IDLE);
		m_tvalid       = (state_q == rma_pkg::ST_OUT);
		cmd.accept     = (state_q == rma_pkg::ST_IDLE) && s_tvalid;
		cmd.load_pass  = (state_q == rma_pkg::ST_DECIDE) && emit_any && stat.pass_mode;
		cmd.div_start  = (state_q == rma_pkg::ST_DECIDE) && emit_any && !stat.pass_mode;
		cmd.div_step   = (state_q == rma_pkg::ST_DIV);
		cmd.div_finish = (state_q == rma_pkg::ST_DIV) && step_last;
		cmd.advance    = (state_q == rma_pkg::ST_OUT) && m_tready;
		// nothing left to emit for this item; the record ends if it was the last
		cmd.rec_end    = (state_q == rma_pkg::ST_DECIDE) && !emit_any;
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output handshakes open at once");

	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rma_pkg::ST_DIV && step_last) |=> m_tvalid)
		else $error("divider finished without presenting a result");

endmodule

@@ hdl/rma_datapath.sv @@
// ----------------------------------------------------------------------------
// rma_datapath: sample ring, sliding sum and divider
// Keeps the sum and count of the window of the next point, the ring of recent
// samples, and an eight-step restoring divider for the rounded mean.
// ----------------------------------------------------------------------------
module rma_datapath #(
	parameter int MAX_WINDOW = rma_pkg::MAX_WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [rma_pkg::WIN_W-1:0]     cfg_data,
	input  logic [rma_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          last_in,
	input  rma_pkg::ctrl_cmd_t            cmd,
	output rma_pkg::dp_status_t           stat,
	output logic [rma_pkg::SAMPLE_W-1:0]  smoothed,
	output logic                          last_out
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 2);
	localparam int SW = rma_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int DW = SW + 1;
	localparam int QW = rma_pkg::DIV_STEPS - 1;

	logic [rma_pkg::WIN_W-1:0]    window_q;
	logic                         rec_start_q;
	logic [CW-1:0]                h_q;
	logic [CW-1:0]                pend_q;
	logic [CW-1:0]                emit_pos_q;
	logic [CW-1:0]                cnt_q;
	logic [SW-1:0]                sum_q;
	logic [AW-1:0]                wr_q;
	logic [AW-1:0]                sub_ptr_q;
	logic [rma_pkg::SAMPLE_W-1:0] sample_q;
	logic                         last_q;
	logic [DW-1:0]                rem_q;
	logic [DW-1:0]                dsh_q;
	logic [QW-1:0]                quo_q;

	logic [8:0]                   win_ext;
	logic [8:0]                   win_clip;
	logic [CW-1:0]                h_new;
	logic [AW-1:0]                sub_init;
	logic [AW-1:0]                wr_nxt;
	logic [AW-1:0]                sub_nxt;
	logic [rma_pkg::SAMPLE_W-1:0] ram_rdata;
	logic                         ge;
	logic                         last_pt;

	assign win_ext  = {2'b00, window_q};
	assign win_clip = (win_ext > 9'(MAX_WINDOW)) ? 9'(MAX_WINDOW) : win_ext;
	assign h_new    = CW'(win_clip >> 1);

	// ring slot of position -h, so that it reaches position 1 as point h+1 leaves
	assign sub_init = (wr_q >= AW'(h_new)) ? (wr_q - AW'(h_new))
		: AW'({1'b0, wr_q} + (AW+1)'(MAX_WINDOW) - {1'b0, AW'(h_new)});
	assign wr_nxt   = (wr_q == AW'(MAX_WINDOW - 1)) ? '0 : wr_q + AW'(1);
	assign sub_nxt  = (sub_ptr_q == AW'(MAX_WINDOW - 1)) ? '0 : sub_ptr_q + AW'(1);

	assign ge      = (rem_q >= dsh_q);
	assign last_pt = last_q && (pend_q == CW'(1));

	assign stat.pend_zero = (pend_q == '0);
	assign stat.pass_mode = (h_q == '0) || (emit_pos_q == '0);
	assign stat.div_ready = last_q || (pend_q >= h_q);

	rma_ram #(
		.WIDTH (rma_pkg::SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (wr_q),
		.wdata (sample),
		.re    (cmd.div_start),
		.raddr (sub_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			rec_start_q <= 1'b1;
			h_q         <= '0;
			pend_q      <= '0;
			emit_pos_q  <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			wr_q        <= '0;
			sub_ptr_q   <= '0;
		end else begin
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			if (cmd.accept) begin
				wr_q <= wr_nxt;
				if (rec_start_q) begin
					rec_start_q <= 1'b0;
					h_q         <= h_new;
					pend_q      <= CW'(1);
					emit_pos_q  <= '0;
					cnt_q       <= '0;
					sum_q       <= '0;
					sub_ptr_q   <= sub_init;
				end else begin
					pend_q <= pend_q + CW'(1);
					cnt_q  <= cnt_q + CW'(1);
					sum_q  <= sum_q + SW'(sample);
				end
			end else if (cmd.advance) begin
				pend_q    <= pend_q - CW'(1);
				sub_ptr_q <= sub_nxt;
				if (emit_pos_q != CW'(MAX_WINDOW + 1)) begin
					emit_pos_q <= emit_pos_q + CW'(1);
				end
				// lower window edge moves past position 1
				if (emit_pos_q > h_q) begin
					sum_q <= sum_q - SW'(ram_rdata);
					cnt_q <= cnt_q - CW'(1);
				end
			end else if (cmd.rec_end && last_q) begin
				rec_start_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			last_q   <= last_in;
		end
		// rounded mean as floor((2*sum + n) / (2*n)), one quotient bit per step
		if (cmd.div_start) begin
			rem_q <= {sum_q, 1'b0} + DW'(cnt_q);
			dsh_q <= DW'({cnt_q, 1'b0}) << (rma_pkg::DIV_STEPS - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? (rem_q - dsh_q) : rem_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
		if (cmd.load_pass) begin
			smoothed <= sample_q;
			last_out <= last_pt;
		end else if (cmd.div_finish) begin
			smoothed <= {quo_q, ge};
			last_out <= last_pt;
		end
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (cnt_q != '0))
		else $error("division started on an empty window");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= h_q + CW'(1))
		else $error("pending points exceed the half window");

endmodule

@@ hdl/record_moving_average.sv @@
// ----------------------------------------------------------------------------
// record_moving_average: box smoothing of a record of 8-bit samples
// Streams a record in, returns each point as the rounded mean of its window.
// ----------------------------------------------------------------------------
// One item is taken at a time. An item that yields one point goes through
// accept, decide, the divider steps, output and decide again, and waits at
// output for any output stall; a pass-through point skips the divider. The
// last item of a record flushes up to window_size/2 points. The restoring
// divider yields one quotient bit per cycle.
// window_size is taken at the first item of each record; values above
// MAX_WINDOW act as MAX_WINDOW, and 0 or 1 pass every sample through.
// ----------------------------------------------------------------------------
module record_moving_average #(
	parameter int MAX_WINDOW = rma_pkg::MAX_WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rma_pkg::WIN_W-1:0]    cfg_data,      // window_size
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rma_pkg::SAMPLE_W-1:0] s_tdata,       // sample
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rma_pkg::SAMPLE_W-1:0] m_tdata,       // smoothed
	output logic                         m_tlast
);

	rma_pkg::ctrl_cmd_t  cmd;
	rma_pkg::dp_status_t stat;

	assign cfg_ready = 1'b1;

	rma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rma_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.sample    (s_tdata),
		.last_in   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.smoothed  (m_tdata),
		.last_out  (m_tlast)
	);

endmodule

@@ tb/rma_checker.sv @@
// ----------------------------------------------------------------------------
// rma_checker: scoreboard for the record moving average
// Watches the config, input and output channels, predicts each smoothed
// point from the accepted samples and compares every output item in order.
// ----------------------------------------------------------------------------
module rma_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [rma_pkg::WIN_W-1:0]    cfg_data,      // window_size
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [rma_pkg::SAMPLE_W-1:0] s_tdata,       // sample
	input  logic                         s_tlast,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [rma_pkg::SAMPLE_W-1:0] m_tdata,       // smoothed
	input  logic                         m_tlast,
	output int                           mismatch_count,
	output int                           points_due
);

	localparam int RING_DEPTH = rma_pkg::MAX_WINDOW_DEF;
	// past this many samples the record start can no longer clip a window
	localparam int POS_LIMIT  = 2 * RING_DEPTH + 1;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [rma_pkg::SAMPLE_W-1:0] smoothed;
		logic                         last;
	} point_t;

	point_t                       point_q[$];
	logic [rma_pkg::WIN_W-1:0]    win_size = '0;
	logic [rma_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
	int unsigned                  wr_ptr   = 0;
	int unsigned                  pos_cnt  = 0;
	int unsigned                  pend_cnt = 0;
	int unsigned                  half_win = 0;
	int                           fails    = 0;
	int                           points_seen = 0;

	assign mismatch_count = fails;

	function automatic logic [rma_pkg::SAMPLE_W-1:0] ring_back(int unsigned back);
		return ring[(wr_ptr + 2 * RING_DEPTH - 1 - back) % RING_DEPTH];
	endfunction

	// mean of the point that lies d samples behind the newest one
	function automatic logic [rma_pkg::SAMPLE_W-1:0] point_mean(int unsigned d);
		int unsigned newest;
		int unsigned lo;
		int unsigned hi;
		int unsigned k;
		int unsigned total;
		int unsigned n;
		bit          exact;
		newest = pos_cnt - 1;
		exact  = pos_cnt < POS_LIMIT;
		total  = 0;
		if (exact && d == newest) begin
			return ring_back(d);
		end
		lo = (d >= half_win - 1) ? d - (half_win - 1) : 0;
		hi = d + half_win;
		if (exact && hi > newest - 1) begin
			hi = newest - 1;
		end
		for (k = lo; k <= hi; k++) begin
			total += ring_back(k);
		end
		n = hi - lo + 1;
		// round half up without fractions
		return rma_pkg::SAMPLE_W'((2 * total + n) / (2 * n));
	endfunction

	task automatic take_sample(input logic [rma_pkg::SAMPLE_W-1:0] smp, input logic lst);
		int unsigned w;
		int unsigned d;
		bit          first_pt;
		point_t      pt;
		if (pos_cnt == 0) begin
			w        = (win_size > RING_DEPTH) ? RING_DEPTH : win_size;
			half_win = (w < 2) ? 0 : w / 2;
			pend_cnt = 0;
		end
		ring[wr_ptr] = smp;
		wr_ptr = (wr_ptr + 1) % RING_DEPTH;
		if (pos_cnt < POS_LIMIT) begin
			pos_cnt++;
		end
		pend_cnt++;
		if (half_win == 0) begin
			pt.smoothed = smp;
			pt.last     = lst;
			point_q.push_back(pt);
			pend_cnt = 0;
		end else begin
			while (pend_cnt > 0) begin
				d        = pend_cnt - 1;
				first_pt = (pos_cnt < POS_LIMIT) && (d == pos_cnt - 1);
				if (!(lst || first_pt || d >= half_win - 1)) begin
					break;
				end
				pt.smoothed = point_mean(d);
				pend_cnt--;
				pt.last = lst && (pend_cnt == 0);
				point_q.push_back(pt);
			end
		end
		if (lst) begin
			pos_cnt  = 0;
			pend_cnt = 0;
		end
	endtask

	task automatic note_mismatch(input string field,
		input logic [rma_pkg::SAMPLE_W-1:0] want_v,
		input logic [rma_pkg::SAMPLE_W-1:0] got_v);
		fails++;
		if (fails <= REPORT_MAX) begin
			$display("checker: point %0d field %s expected %0d got %0d",
				points_seen, field, want_v, got_v);
		end
	endtask

	task automatic check_point();
		point_t want;
		if (point_q.size() == 0) begin
			fails++;
			if (fails <= REPORT_MAX) begin
				$display("checker: point %0d not expected, smoothed %0d last %0b",
					points_seen, m_tdata, m_tlast);
			end
		end else begin
			want = point_q.pop_front();
			if (m_tdata !== want.smoothed) begin
				note_mismatch("smoothed", want.smoothed, m_tdata);
			end
			if (m_tlast !== want.last) begin
				note_mismatch("last", rma_pkg::SAMPLE_W'(want.last),
					rma_pkg::SAMPLE_W'(m_tlast));
			end
		end
		points_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size = '0;
			wr_ptr   = 0;
			pos_cnt  = 0;
			pend_cnt = 0;
			half_win = 0;
			point_q.delete();
			points_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_size = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				take_sample(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				check_point();
			end
			points_due <= point_q.size();
		end
	end

endmodule

@@ tb/tb_record_moving_average.sv @@
// ----------------------------------------------------------------------------
// tb_record_moving_average: testbench for the record moving average
// Directed records at the window and sample extremes, a long record under a
// held-off output, then random records over several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_record_moving_average;

	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_RUN      = 130;
	localparam int PHASE_ITEMS   = 22;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [rma_pkg::WIN_W-1:0]    cfg_data  = '0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	logic [rma_pkg::SAMPLE_W-1:0] s_tdata   = '0;
	logic                         s_tlast   = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	logic [rma_pkg::SAMPLE_W-1:0] m_tdata;
	logic                         m_tlast;

	int                  mismatch_count;
	int                  points_due;
	int                  src_idle   = 0;
	int                  sink_stall = 0;
	logic                hold_req   = 1'b0;
	int                  hold_left  = 0;
	int                  quiet      = 0;

	always #5 clk = ~clk;

	record_moving_average u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	rma_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.points_due     (points_due)
	);

	// output side: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= sink_stall);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic cfg_write(input logic [rma_pkg::WIN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input logic [rma_pkg::SAMPLE_W-1:0] smp, input logic lst);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
	endtask

	// wait until every predicted point has come out and the block is idle
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (points_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [rma_pkg::WIN_W-1:0] pick_window();
		case ($urandom_range(0, 7))
			0:       return rma_pkg::WIN_W'(0);
			1:       return rma_pkg::WIN_W'(1);
			2:       return rma_pkg::WIN_W'(2);
			3:       return rma_pkg::WIN_W'(64);
			4:       return rma_pkg::WIN_W'(127);
			5:       return rma_pkg::WIN_W'($urandom_range(65, 126));
			default: return rma_pkg::WIN_W'($urandom_range(3, 20));
		endcase
	endfunction

	task automatic run_phase(input int idle_pct, input int stall_pct);
		int unsigned taken;
		int unsigned len;
		int unsigned i;
		src_idle   <= idle_pct;
		sink_stall <= stall_pct;
		taken = 0;
		while (taken < PHASE_ITEMS) begin
			if ($urandom_range(0, 1) == 1) begin
				settle();
				cfg_write(pick_window());
			end
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
			for (i = 1; i <= len; i++) begin
				send_item(rma_pkg::SAMPLE_W'($urandom_range(0, 255)), i == len);
			end
			taken += len;
		end
	endtask

	initial begin : stimulus
		int unsigned i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window after reset passes samples through
		send_item(8'd0, 1'b0);
		send_item(8'd255, 1'b0);
		send_item(8'd85, 1'b1);
		settle();
		cfg_write(7'd1);
		send_item(8'd255, 1'b1);
		settle();
		cfg_write(7'd4);
		send_item(8'd0, 1'b0);
		send_item(8'd255, 1'b0);
		send_item(8'd255, 1'b0);
		send_item(8'd0, 1'b0);
		send_item(8'd128, 1'b1);
		settle();
		// odd window rounds the half width down
		cfg_write(7'd5);
		send_item(8'd10, 1'b0);
		send_item(8'd20, 1'b0);
		send_item(8'd30, 1'b1);
		settle();
		// oversized window acts as the largest one
		cfg_write(7'd127);
		send_item(8'd3, 1'b0);
		send_item(8'd250, 1'b0);
		send_item(8'd7, 1'b0);
		send_item(8'd128, 1'b0);
		send_item(8'd1, 1'b1);
		send_item(8'd200, 1'b1);
		settle();
		// a write in the middle of a record waits for the next one
		cfg_write(7'd0);
		send_item(8'd1, 1'b0);
		send_item(8'd2, 1'b0);
		settle();
		cfg_write(7'd6);
		send_item(8'd3, 1'b0);
		send_item(8'd4, 1'b1);
		send_item(8'd5, 1'b0);
		send_item(8'd6, 1'b0);
		send_item(8'd7, 1'b1);
		settle();

		// long record behind a held-off output, long enough to saturate the
		// position count
		cfg_write(7'd64);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		for (i = 1; i <= LONG_RUN; i++) begin
			send_item(rma_pkg::SAMPLE_W'($urandom_range(0, 255)), i == LONG_RUN);
		end
		settle();

		run_phase(0, 0);
		run_phase(82, 0);
		run_phase(0, 82);
		run_phase(28, 28);

		settle();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && points_due == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/rma_pkg.sv
hdl/rma_ram.sv
hdl/rma_ctrl.sv
hdl/rma_datapath.sv
hdl/record_moving_average.sv
tb/rma_checker.sv
tb/tb_record_moving_average.sv
